// ----- design/toe_pkg.sv -----
// ----------------------------------------------------------------------------
// toe_pkg
// shared constants and types of the topological order engine
// ----------------------------------------------------------------------------
package toe_pkg;

  localparam int unsigned MaxNodes  = 32;
  localparam int unsigned MaxEdges  = 256;
  localparam int unsigned NodeW     = 5;
  localparam int unsigned EdgeAw    = $clog2(MaxEdges);
  localparam int unsigned EdgeCntW  = EdgeAw + 1;
  localparam int unsigned DegW      = EdgeAw + 1;
  localparam int unsigned NodeAw    = $clog2(MaxNodes);
  localparam int unsigned NodeCntW  = NodeAw + 1;
  localparam int unsigned CountW    = 6;
  localparam int unsigned NodeLimit = (MaxNodes < 32) ? MaxNodes : 32;

  localparam logic       OpAdd = 1'b0;
  localparam logic       OpRun = 1'b1;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatCycle   = 2'd1;
  localparam logic [1:0] StatOverflow = 2'd2;
  localparam logic [1:0] StatBadNode = 2'd3;

  // one stored edge
  typedef struct packed {
    logic [NodeW-1:0] src;
    logic [NodeW-1:0] dst;
  } edge_t;

  // result item
  typedef struct packed {
    logic             last;
    logic [1:0]       status;
    logic [NodeW-1:0] node;
  } result_t;

endpackage

// ----- design/topological_order_engine.sv -----
// topological order engine: kahn sort over an edge memory
// an edge load is taken while idle, edges back to back at one per cycle
// a run checks the stored edges against the count; a load error gives one error item,
//   else it seeds the zero degree nodes, sorts and gives one result per cycle through
//   an output register (stalls hold it); input is held off until the clear state is done
// reset (rst_ni low, async) clears counters, errors, degree valid bits; node_count=32
// ----------------------------------------------------------------------------
// topological_order_engine
// loads dependency edges and emits a topological order on a run item
// ----------------------------------------------------------------------------
module topological_order_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // before_node, after_node
  input  logic        s_axis_tuser_i,  // op
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // node_index
  output logic [1:0]  m_axis_tuser_o,  // status
  output logic        m_axis_tlast_o,  // last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import toe_pkg::*;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StChk   = 4'd1;  // check stored edges against count
  localparam logic [3:0] StSeed  = 4'd2;  // push zero degree nodes
  localparam logic [3:0] StPop   = 4'd3;
  localparam logic [3:0] StScan  = 4'd4;  // edge read address issued
  localparam logic [3:0] StEmit  = 4'd5;
  localparam logic [3:0] StErr   = 4'd6;
  localparam logic [3:0] StDegRd = 4'd7;  // edge data back, match against popped node
  localparam logic [3:0] StChkW  = 4'd8;
  localparam logic [3:0] StDec   = 4'd9;  // decrement target degree, push on zero
  localparam logic [3:0] StClr   = 4'd10; // clear graph

  // config register
  logic [CountW-1:0] node_count_q;
  logic              cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr == 2'd0);
  assign prdata = {26'd0, node_count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CountW'(32);
    end else if (cfg_wr) begin
      node_count_q <= pwdata[CountW-1:0];
    end
  end

  // effective node count: zero acts as one, larger values saturate at NodeLimit
  logic [NodeCntW-1:0] live_n;
  always_comb begin
    if (node_count_q == '0) live_n = NodeCntW'(1);
    else if (32'(node_count_q) > NodeLimit) live_n = NodeCntW'(NodeLimit);
    else live_n = NodeCntW'(node_count_q);
  end

  logic             in_op;
  logic [NodeW-1:0] in_a, in_b;
  assign in_op = s_axis_tuser_i;
  assign in_a  = s_axis_tdata_i[4:0];
  assign in_b  = s_axis_tdata_i[9:5];

  logic [3:0]          state_q;
  logic [EdgeCntW-1:0] edge_total_q;
  logic [1:0]          load_err_q;
  logic [EdgeCntW-1:0] eidx_q;
  logic [NodeCntW-1:0] nidx_q;
  logic [NodeCntW-1:0] sp_q;
  logic [NodeCntW-1:0] olen_q;
  logic [NodeCntW-1:0] emit_q;
  logic [NodeW-1:0]    cur_q;
  logic [NodeW-1:0]    tgt_q;
  logic                fail_q;

  // degree counters: small array, valid bits clear on run end
  logic [DegW-1:0]  deg_q [MaxNodes];
  logic             deg_v_q [MaxNodes];
  logic [NodeW-1:0] stack_q [MaxNodes];
  logic [NodeW-1:0] order_q [MaxNodes];

  result_t out_q;
  logic    out_v_q;
  logic    out_free;
  logic    out_load;
  assign out_free = !out_v_q || m_axis_tready_i;
  assign out_load = out_free && (state_q == StErr || state_q == StEmit);

  logic in_fire;
  assign s_axis_tready_o = (state_q == StIdle);
  assign in_fire = s_axis_tvalid_i & s_axis_tready_o;

  logic add_ok;
  assign add_ok = in_fire && in_op == OpAdd && NodeCntW'(in_a) < live_n &&
                  NodeCntW'(in_b) < live_n && edge_total_q < EdgeCntW'(MaxEdges);

  // edge memory
  edge_t                e_rd;
  logic [EdgeAw-1:0]    e_raddr;
  edge_t                e_wd;
  assign e_wd    = '{src: in_a, dst: in_b};
  assign e_raddr = eidx_q[EdgeAw-1:0];

  toe_edge_ram u_edges (
    .clk_i   (clk_i),
    .we_i    (add_ok),
    .waddr_i (edge_total_q[EdgeAw-1:0]),
    .wdata_i (e_wd),
    .raddr_i (e_raddr),
    .rdata_o (e_rd)
  );

  function automatic logic [DegW-1:0] deg_rd(input logic v, input logic [DegW-1:0] d);
    return v ? d : '0;
  endfunction

  logic [DegW-1:0] tdeg;
  assign tdeg = deg_rd(deg_v_q[tgt_q[NodeAw-1:0]], deg_q[tgt_q[NodeAw-1:0]]);

  logic [DegW-1:0] ndeg;
  assign ndeg = deg_rd(deg_v_q[nidx_q[NodeAw-1:0]], deg_q[nidx_q[NodeAw-1:0]]);

  always_ff @(posedge clk_i) begin
    if (add_ok) begin
      deg_q[in_b[NodeAw-1:0]] <= deg_rd(deg_v_q[in_b[NodeAw-1:0]],
                                        deg_q[in_b[NodeAw-1:0]]) + DegW'(1);
    end else if (state_q == StDec && NodeCntW'(tgt_q) < live_n && tdeg != '0) begin
      deg_q[tgt_q[NodeAw-1:0]] <= tdeg - DegW'(1);
    end
    if (state_q == StSeed && nidx_q < live_n && ndeg == '0) begin
      stack_q[sp_q[NodeAw-1:0]] <= nidx_q[NodeW-1:0];
    end else if (state_q == StDec && NodeCntW'(tgt_q) < live_n &&
                 tdeg == DegW'(1) && sp_q < NodeCntW'(MaxNodes)) begin
      stack_q[sp_q[NodeAw-1:0]] <= tgt_q;
    end
    if (state_q == StPop && sp_q != '0) begin
      order_q[olen_q[NodeAw-1:0]] <= stack_q[NodeAw'(sp_q - NodeCntW'(1))];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      edge_total_q <= '0;
      load_err_q   <= StatOk;
      eidx_q       <= '0;
      nidx_q       <= '0;
      sp_q         <= '0;
      olen_q       <= '0;
      emit_q       <= '0;
      cur_q        <= '0;
      tgt_q        <= '0;
      fail_q       <= 1'b0;
      out_v_q      <= 1'b0;
      out_q        <= '0;
      for (int i = 0; i < MaxNodes; i++) deg_v_q[i] <= 1'b0;
    end else begin
      if (out_load) out_v_q <= 1'b1;
      else if (m_axis_tready_i) out_v_q <= 1'b0;
      if (add_ok) deg_v_q[in_b[NodeAw-1:0]] <= 1'b1;
      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            if (in_op == OpAdd) begin
              if (add_ok) begin
                edge_total_q <= edge_total_q + EdgeCntW'(1);
              end else if (load_err_q == StatOk) begin
                load_err_q <= (NodeCntW'(in_a) >= live_n || NodeCntW'(in_b) >= live_n)
                              ? StatBadNode : StatOverflow;
              end
            end else begin
              eidx_q  <= '0;
              state_q <= StChk;
            end
          end
        end
        StChk: begin
          // address issued, data next cycle
          if (eidx_q >= edge_total_q) begin
            nidx_q  <= '0;
            sp_q    <= '0;
            olen_q  <= '0;
            state_q <= (load_err_q != StatOk) ? StErr : StSeed;
          end else begin
            state_q <= StChkW;
          end
        end
        StChkW: begin
          if ((NodeCntW'(e_rd.src) >= live_n || NodeCntW'(e_rd.dst) >= live_n) &&
              load_err_q == StatOk) begin
            load_err_q <= StatBadNode;
          end
          eidx_q  <= eidx_q + EdgeCntW'(1);
          state_q <= StChk;
        end
        StSeed: begin
          if (nidx_q < live_n) begin
            if (ndeg == '0) sp_q <= sp_q + NodeCntW'(1);
            nidx_q <= nidx_q + NodeCntW'(1);
          end else begin
            state_q <= StPop;
          end
        end
        StPop: begin
          if (sp_q == '0) begin
            fail_q  <= (olen_q != live_n);
            emit_q  <= '0;
            state_q <= StEmit;
          end else begin
            cur_q   <= stack_q[NodeAw'(sp_q - NodeCntW'(1))];
            sp_q    <= sp_q - NodeCntW'(1);
            olen_q  <= olen_q + NodeCntW'(1);
            eidx_q  <= '0;
            state_q <= StScan;
          end
        end
        StScan: begin
          if (eidx_q >= edge_total_q) begin
            state_q <= StPop;
          end else begin
            state_q <= StDegRd;
          end
        end
        StDegRd: begin
          // e_rd holds edge eidx_q
          if (e_rd.src == cur_q) begin
            tgt_q   <= e_rd.dst;
            state_q <= StDec;
          end else begin
            eidx_q  <= eidx_q + EdgeCntW'(1);
            state_q <= StScan;
          end
        end
        StDec: begin
          if (NodeCntW'(tgt_q) < live_n && tdeg == DegW'(1) &&
              sp_q < NodeCntW'(MaxNodes)) begin
            sp_q <= sp_q + NodeCntW'(1);
          end
          eidx_q  <= eidx_q + EdgeCntW'(1);
          state_q <= StScan;
        end
        StErr: begin
          if (out_load) begin
            out_q   <= '{last: 1'b1, status: load_err_q, node: '0};
            state_q <= StClr;
          end
        end
        StEmit: begin
          if (out_load) begin
            if (fail_q) begin
              out_q   <= '{last: 1'b1, status: StatCycle, node: '0};
              state_q <= StClr;
            end else begin
              out_q  <= '{last: (emit_q + NodeCntW'(1) == olen_q), status: StatOk,
                          node: order_q[emit_q[NodeAw-1:0]]};
              emit_q <= emit_q + NodeCntW'(1);
              if (emit_q + NodeCntW'(1) == olen_q) state_q <= StClr;
            end
          end
        end
        StClr: begin
          edge_total_q <= '0;
          load_err_q   <= StatOk;
          for (int i = 0; i < MaxNodes; i++) deg_v_q[i] <= 1'b0;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {3'b0, out_q.node};
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tlast_o  = out_q.last;

endmodule

// ----- design/toe_edge_ram.sv -----
// ----------------------------------------------------------------------------
// toe_edge_ram
// edge store, one write and one registered read port
// ----------------------------------------------------------------------------
module toe_edge_ram (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [toe_pkg::EdgeAw-1:0] waddr_i,
  input  toe_pkg::edge_t         wdata_i,
  input  logic [toe_pkg::EdgeAw-1:0] raddr_i,
  output toe_pkg::edge_t         rdata_o
);
  import toe_pkg::*;

  edge_t mem_q [MaxEdges];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the topological order engine: edge loads and sort runs go in over
// the input stream, node_count goes in over apb, and every output transfer
// is compared against an in-bench kahn sort of the same graph or a status item
// written in by hand
module testbench;
  import toe_pkg::*;

  typedef enum logic [1:0] {RowAdd, RowRun, RowCfg} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    logic [5:0] a;       // before_node, or node_count for a cfg row
    logic [4:0] b;       // after_node
    bit         typed;   // expected status item written in by hand
    logic [1:0] stat;
    logic [4:0] node;
  } row_t;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned HoldCycles = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  always #5 clk_i = ~clk_i;

  topological_order_engine dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),   // before_node, after_node
    .s_axis_tuser_i (s_tuser),   // op
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),   // node_index
    .m_axis_tuser_o (m_tuser),   // status
    .m_axis_tlast_o (m_tlast),   // last
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // --------------------------------------------------------------------------
  // graph mirror: what the block should hold after every accepted transfer
  // --------------------------------------------------------------------------
  logic [4:0] edge_src [MaxEdges];
  logic [4:0] edge_dst [MaxEdges];
  int         edge_cnt;
  int         in_degree [NodeLimit];
  logic [1:0] held_err;
  logic [5:0] node_count_q;

  result_t    order_q [$];   // expected output transfers, oldest first
  int         fail_cnt;
  int         run_cnt;
  int         result_cnt;
  int         cycle_cnt;

  // idling and pressure controls, owned by the stimulus process
  bit         quiet;
  logic       hold_req = 1'b0;

  function automatic int live_nodes();
    int n;
    n = node_count_q;
    if (n < 1) n = 1;
    if (n > NodeLimit) n = NodeLimit;
    return n;
  endfunction

  function automatic void clear_graph();
    edge_cnt = 0;
    held_err = StatOk;
    for (int i = 0; i < NodeLimit; i++) in_degree[i] = 0;
  endfunction

  function automatic void latch_err(logic [1:0] code);
    if (held_err == StatOk) held_err = code;
  endfunction

  function automatic void load_edge(logic [4:0] a, logic [4:0] b);
    int n;
    n = live_nodes();
    if (a >= n || b >= n) latch_err(StatBadNode);
    else if (edge_cnt >= MaxEdges) latch_err(StatOverflow);
    else begin
      edge_src[edge_cnt] = a;
      edge_dst[edge_cnt] = b;
      edge_cnt++;
      in_degree[b]++;
    end
  endfunction

  // kahn sort with a lifo ready list, returns the transfers a run produces
  function automatic void sort_graph(ref result_t items [$]);
    int         n;
    logic [4:0] ready [$];
    logic [4:0] order [$];
    logic [4:0] v;
    int         t;
    n = live_nodes();
    items = {};
    // edges loaded under a larger count may now be out of range
    for (int e = 0; e < edge_cnt; e++)
      if (edge_src[e] >= n || edge_dst[e] >= n) latch_err(StatBadNode);
    if (held_err != StatOk) begin
      items.insert(items.size(), '{last: 1'b1, status: held_err, node: '0});
    end else begin
      for (int i = 0; i < n; i++) if (in_degree[i] == 0) ready.insert(ready.size(), i[4:0]);
      while (ready.size() > 0) begin
        v = ready.pop_back();
        order.insert(order.size(), v);
        for (int e = 0; e < edge_cnt; e++) begin
          if (edge_src[e] != v) continue;
          t = edge_dst[e];
          if (t >= n || in_degree[t] == 0) continue;
          in_degree[t]--;
          if (in_degree[t] == 0) ready.insert(ready.size(), t[4:0]);
        end
      end
      if (order.size() != n) begin
        items.insert(items.size(), '{last: 1'b1, status: StatCycle, node: '0});
      end else begin
        foreach (order[k])
          items.insert(items.size(),
                       '{last: (k == n - 1), status: StatOk, node: order[k]});
      end
    end
    clear_graph();
  endfunction

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------
  // tvalid stays high across back-to-back transfers but for random idle gaps when not
  // quiet; anything that spends time between two calls drops it first
  task automatic send_item(logic op, logic [4:0] a, logic [4:0] b);
    while (!quiet && $urandom_range(99) < 13) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, b, a};
    s_tuser  <= op;
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic add_edge(logic [4:0] a, logic [4:0] b);
    send_item(OpAdd, a, b);
    load_edge(a, b);
  endtask

  task automatic run_sort(bit typed = 0, logic [1:0] stat = StatOk, logic [4:0] node = '0);
    result_t items [$];
    send_item(OpRun, 5'($urandom_range(31)), 5'($urandom_range(31)));
    sort_graph(items);
    if (typed) items = '{'{last: 1'b1, status: stat, node: node}};
    foreach (items[i]) order_q.insert(order_q.size(), items[i]);
    run_cnt++;
  endtask

  // every expected transfer out, then a margin for a trailing edge load
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (order_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_node_count(logic [5:0] value);
    wait_idle();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= '0;
    pwdata  <= {26'b0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    node_count_q = value;
  endtask

  // --------------------------------------------------------------------------
  // output side: random stalls, one long hold-off on request
  // --------------------------------------------------------------------------
  int hold_left = 0;
  bit hold_taken = 0;

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HoldCycles;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= quiet || ($urandom_range(99) >= 13);
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      result_cnt++;
      if (order_q.size() == 0) begin
        $error("unexpected output transfer: node %0d status %0d last %0b",
               m_tdata[4:0], m_tuser, m_tlast);
        fail_cnt++;
      end else begin
        want = order_q.pop_front();
        if (m_tdata[4:0] !== want.node) begin
          $error("node_index: expected %0d, got %0d", want.node, m_tdata[4:0]);
          fail_cnt++;
        end
        if (m_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser);
          fail_cnt++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_tlast);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // directed table: extremes, every op and each corner of the sort
  // --------------------------------------------------------------------------
  row_t plan [$] = '{
    '{RowRun, 6'd0,  5'd0,  0, StatOk,      5'd0},  // empty graph, full count: descending
    '{RowAdd, 6'd31, 5'd30, 0, StatOk,      5'd0},
    '{RowAdd, 6'd30, 5'd0,  0, StatOk,      5'd0},
    '{RowAdd, 6'd0,  5'd1,  0, StatOk,      5'd0},
    '{RowRun, 6'd0,  5'd0,  0, StatOk,      5'd0},
    '{RowAdd, 6'd0,  5'd1,  0, StatOk,      5'd0},  // two-node loop
    '{RowAdd, 6'd1,  5'd0,  0, StatOk,      5'd0},
    '{RowRun, 6'd0,  5'd0,  1, StatCycle,   5'd0},
    '{RowCfg, 6'd0,  5'd0,  0, StatOk,      5'd0},  // zero count acts as one node
    '{RowRun, 6'd0,  5'd0,  1, StatOk,      5'd0},
    '{RowAdd, 6'd0,  5'd0,  0, StatOk,      5'd0},  // self loop
    '{RowRun, 6'd0,  5'd0,  1, StatCycle,   5'd0},
    '{RowCfg, 6'd4,  5'd0,  0, StatOk,      5'd0},
    '{RowAdd, 6'd7,  5'd2,  0, StatOk,      5'd0},  // bad node, first error sticks
    '{RowAdd, 6'd0,  5'd1,  0, StatOk,      5'd0},
    '{RowAdd, 6'd1,  5'd31, 0, StatOk,      5'd0},
    '{RowRun, 6'd0,  5'd0,  1, StatBadNode, 5'd0},
    '{RowAdd, 6'd3,  5'd2,  0, StatOk,      5'd0},  // count lowered after loading
    '{RowCfg, 6'd2,  5'd0,  0, StatOk,      5'd0},
    '{RowRun, 6'd0,  5'd0,  1, StatBadNode, 5'd0},
    '{RowCfg, 6'd63, 5'd0,  0, StatOk,      5'd0},  // saturates to the full count
    '{RowAdd, 6'd31, 5'd15, 0, StatOk,      5'd0},
    '{RowAdd, 6'd15, 5'd16, 0, StatOk,      5'd0},
    '{RowRun, 6'd0,  5'd0,  0, StatOk,      5'd0}
  };

  initial begin
    int         n;
    int         k;
    int         flavor;
    int         items_sent;
    int         i;
    int         j;
    logic [4:0] perm [$];
    logic [4:0] tmp;

    node_count_q = 6'd32;
    clear_graph();
    fail_cnt   = 0;
    run_cnt    = 0;
    result_cnt = 0;
    cycle_cnt  = 0;
    quiet      = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r]) begin
      case (plan[r].kind)
        RowAdd: add_edge(plan[r].a[4:0], plan[r].b);
        RowRun: run_sort(plan[r].typed, plan[r].stat, plan[r].node);
        default: write_node_count(plan[r].a);
      endcase
    end

    // full edge store plus one: overflow reported at run
    write_node_count(6'd32);
    for (int e = 0; e <= MaxEdges; e++)
      add_edge(5'($urandom_range(31)), 5'($urandom_range(31)));
    run_sort(1, StatOverflow, '0);

    // back-pressure: a long hold-off while a full-count order is pending,
    // with more edges offered behind it so the input has to stall
    write_node_count(6'd32);
    hold_req <= 1'b1;
    run_sort();
    for (int e = 0; e < 20; e++) add_edge(5'($urandom_range(31)), 5'($urandom_range(31)));
    run_sort();

    // random graphs: mostly dags in shuffled order, some loops, bad nodes, noise
    items_sent = 0;
    for (int g = 0; items_sent < 150 || g < 20; g++) begin
      quiet = (g >= 6 && g < 10);
      if ($urandom_range(9) == 0) write_node_count(6'($urandom_range(32, 63)));
      else write_node_count(6'($urandom_range(0, 12)));
      n = live_nodes();
      perm = {};
      for (int v = 0; v < n; v++) perm.insert(perm.size(), v[4:0]);
      for (int v = n - 1; v > 0; v--) begin
        j = $urandom_range(v);
        tmp = perm[v];
        perm[v] = perm[j];
        perm[j] = tmp;
      end
      flavor = $urandom_range(9);
      k = (n > 1) ? $urandom_range(2 * n) : 0;
      if (flavor == 9) begin
        for (int e = 0; e < k + 1; e++)
          add_edge(5'($urandom_range(31)), 5'($urandom_range(31)));
        items_sent += k + 1;
      end else begin
        for (int e = 0; e < k; e++) begin
          i = $urandom_range(n - 2);
          j = $urandom_range(i + 1, n - 1);
          add_edge(perm[i], perm[j]);
        end
        items_sent += k;
        if (flavor == 7 && n > 1) begin
          i = $urandom_range(n - 2);
          j = $urandom_range(i + 1, n - 1);
          add_edge(perm[j], perm[i]);
          items_sent++;
        end else if (flavor == 8 && n < 32) begin
          add_edge(5'($urandom_range(n, 31)), perm[0]);
          items_sent++;
        end
      end
      run_sort();
      items_sent++;
    end
    quiet = 0;

    s_tvalid <= 1'b0;
    while (order_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("summary: %0d sort runs, %0d output transfers checked", run_cnt, result_cnt);
    $display("summary: dags, loops, bad nodes, full edge store, counts 0 to 63, long hold-off");
    if (fail_cnt == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/toe_pkg.sv
design/toe_edge_ram.sv
design/topological_order_engine.sv
bench/testbench.sv
